// File: src/lrcf_pkg.sv
// Package: widths, packing constants, stage enables and the sigmoid table.
`timescale 1ns / 1ps
package lrcf_pkg;

  localparam int DATA_WIDTH      = 16;
  localparam int FRAC_BITS       = 8;
  localparam int SIG_ENTRIES     = 256;

  localparam int GATE_W    = FRAC_BITS + 1;              // gate 0..1.0, unsigned
  localparam int IDX_W     = $clog2(SIG_ENTRIES);
  localparam int SHIFT_W   = DATA_WIDTH + FRAC_BITS + 2; // x + 8.0, signed
  localparam int PROD_W    = DATA_WIDTH + GATE_W + 1;    // gate * data, signed
  localparam int SUM_W     = PROD_W + 1;
  localparam int HPROD_W   = GATE_W + DATA_WIDTH - 1;    // gate * positive cell
  localparam int HID_W     = DATA_WIDTH - 1;

  localparam int IN_DATA_W  = ((5 * DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((DATA_WIDTH + HID_W + 7) / 8) * 8;

  typedef logic [GATE_W-1:0] gate_t;
  typedef gate_t sig_tab_t [SIG_ENTRIES];

  typedef struct packed {
    logic load_a;
    logic load_b;
  } lrcf_stage_en_t;

  // shift-subtract quotient, only used while building the table
  function automatic longint unsigned udiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | ((n >> b) & 64'd1);
      if (rem >= d) begin
        rem = rem - d;
        q = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  function automatic sig_tab_t build_sig_tab();
    sig_tab_t tab;
    longint d;
    longint acc;
    longint unsigned mag;
    longint unsigned r;
    longint unsigned term;
    longint unsigned e;
    longint unsigned num;
    longint unsigned den;
    longint unsigned q30;
    q30 = 64'd1 << 30;
    for (int k = 0; k < SIG_ENTRIES; k++) begin
      d = 2 * longint'(k) - longint'(SIG_ENTRIES);
      mag = (d < 0) ? longint'(-d) : longint'(d);
      r = udiv(mag << 30, 2 * longint'(SIG_ENTRIES));
      term = q30;
      acc = longint'(q30);
      for (int t = 1; t <= 12; t++) begin
        term = udiv((term * r) >> 30, longint'(t));
        if ((t & 1) == 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
      e = (acc > 0) ? longint'(acc) : 64'd0;
      for (int s = 0; s < 4; s++) e = (e * e) >> 30;
      num = (d >= 0) ? q30 : e;
      den = q30 + e;
      tab[k] = GATE_W'(udiv((num << FRAC_BITS) + (den >> 1), den));
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TAB = build_sig_tab();

endpackage

// File: src/lrcf_sigmoid.sv
// Clamped table sigmoid for one Q-format gate pre-activation.
`timescale 1ns / 1ps
module lrcf_sigmoid (
  input  logic signed [lrcf_pkg::DATA_WIDTH-1:0] x,
  output lrcf_pkg::gate_t                        y
);
  import lrcf_pkg::*;

  localparam int MUL_W = SHIFT_W + IDX_W + 1;
  localparam logic signed [SHIFT_W-1:0] OFFSET = SHIFT_W'(8) <<< FRAC_BITS;

  logic signed [SHIFT_W-1:0] shifted;
  logic [MUL_W-1:0]          scaled;
  logic [MUL_W-1:0]          idx_wide;
  logic [IDX_W-1:0]          idx;

  always_comb begin
    shifted  = SHIFT_W'(x) + OFFSET;
    scaled   = MUL_W'(shifted) * MUL_W'(SIG_ENTRIES);
    idx_wide = scaled >> (FRAC_BITS + 4);
    if (shifted < 0) idx = '0;
    else if (idx_wide >= MUL_W'(SIG_ENTRIES)) idx = IDX_W'(SIG_ENTRIES - 1);
    else idx = idx_wide[IDX_W-1:0];
    y = SIG_TAB[idx];
  end

endmodule

// File: src/lrcf_cell_path.sv
// Cell update stages: gate products, then sum, round and saturate.
`timescale 1ns / 1ps
module lrcf_cell_path (
  input  logic                                   clk,
  input  lrcf_pkg::lrcf_stage_en_t               en,
  input  lrcf_pkg::gate_t                        ig,
  input  lrcf_pkg::gate_t                        fg,
  input  lrcf_pkg::gate_t                        og,
  input  logic signed [lrcf_pkg::DATA_WIDTH-1:0] g,
  input  logic signed [lrcf_pkg::DATA_WIDTH-1:0] cp,
  input  logic                                   last_in,
  output logic signed [lrcf_pkg::DATA_WIDTH-1:0] cell_out,
  output lrcf_pkg::gate_t                        og_out,
  output logic                                   last_out
);
  import lrcf_pkg::*;

  localparam logic signed [SUM_W-1:0] CMAX = {{(SUM_W-DATA_WIDTH+1){1'b0}},
                                               {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] CMIN = {{(SUM_W-DATA_WIDTH+1){1'b1}},
                                               {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

  logic signed [PROD_W-1:0] pf;
  logic signed [PROD_W-1:0] pi;
  gate_t                    og_a;
  logic                     last_a;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  rnd;
  logic signed [DATA_WIDTH-1:0] cell_next;

  always_ff @(posedge clk) begin
    if (en.load_a) begin
      pf     <= PROD_W'($signed({1'b0, fg})) * PROD_W'(cp);
      pi     <= PROD_W'($signed({1'b0, ig})) * PROD_W'(g);
      og_a   <= og;
      last_a <= last_in;
    end
  end

  always_comb begin
    sum = SUM_W'(pf) + SUM_W'(pi) + HALF;
    rnd = sum >>> FRAC_BITS;
    if (rnd > CMAX) cell_next = CMAX[DATA_WIDTH-1:0];
    else if (rnd < CMIN) cell_next = CMIN[DATA_WIDTH-1:0];
    else cell_next = rnd[DATA_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (en.load_b) begin
      cell_out <= cell_next;
      og_out   <= og_a;
      last_out <= last_a;
    end
  end

endmodule

// File: src/lrcf_hidden_path.sv
// Hidden value stages: output gate times positive cell, round and saturate.
`timescale 1ns / 1ps
module lrcf_hidden_path (
  input  logic                                   clk,
  input  lrcf_pkg::lrcf_stage_en_t               en,
  input  logic signed [lrcf_pkg::DATA_WIDTH-1:0] cell_in,
  input  lrcf_pkg::gate_t                        og,
  input  logic                                   last_in,
  output logic [lrcf_pkg::DATA_WIDTH-1:0]        cell_new,
  output logic [lrcf_pkg::HID_W-1:0]             hidden_new,
  output logic                                   last_out
);
  import lrcf_pkg::*;

  localparam logic [HPROD_W:0] HALF = (HPROD_W + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [HPROD_W:0] HMAX = (HPROD_W + 1)'({HID_W{1'b1}});

  logic [HID_W-1:0]      cpos;
  logic [HPROD_W-1:0]    hp;
  logic [DATA_WIDTH-1:0] cell_a;
  logic                  last_a;
  logic [HPROD_W:0]      hr;
  logic [HID_W-1:0]      hidden_next;

  assign cpos = (cell_in > 0) ? cell_in[HID_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (en.load_a) begin
      hp     <= HPROD_W'(og) * HPROD_W'(cpos);
      cell_a <= cell_in;
      last_a <= last_in;
    end
  end

  always_comb begin
    hr = ((HPROD_W + 1)'(hp) + HALF) >> FRAC_BITS;
    hidden_next = (hr > HMAX) ? HMAX[HID_W-1:0] : hr[HID_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en.load_b) begin
      cell_new   <= cell_a;
      hidden_new <= hidden_next;
      last_out   <= last_a;
    end
  end

endmodule

// File: src/lstm_relu_cell_forward_unit.sv
// LSTM cell elementwise update with ReLU candidate: top level.
// Usage:
//   Slave channel s_*: one cell element per request. s_tdata carries the
//   input, forget and output gate pre-activations, the candidate and the
//   previous cell value (signed Q8.8); s_tuser is the sequence-continue
//   marker (0 zeroes the forget gate); s_tlast marks the last element.
//   Master channel m_*: m_tdata carries the new cell value and the hidden
//   value o*max(c,0), both saturated; m_tlast copies s_tlast.
// Timing: five register stages (sigmoid lookup, gate products, cell sum,
//   hidden product, hidden rounding), passed in that order. One request per
//   cycle is sustained while m_tready is high, since every stage advances
//   whenever the stage after it moves.
// Stall: each stage holds while the next one is full and blocked, so empty
//   stages still fill while m_tready is low; s_tready falls only when all
//   five stages hold data. Nothing is lost or repeated.
// Reset: rst clears all stage valid bits; the pipeline is empty after it.
`timescale 1ns / 1ps
module lstm_relu_cell_forward_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // input_gate_pre, forget_gate_pre, output_gate_pre, candidate_pre, cell_prev
  input  logic [lrcf_pkg::IN_DATA_W-1:0]    s_tdata,
  // sequence_continue
  input  logic                              s_tuser,
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // cell_new, hidden_new, zero pad
  output logic [lrcf_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                              m_tlast
);
  import lrcf_pkg::*;

  localparam int NSTG = 5;
  localparam int DW   = DATA_WIDTH;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  logic signed [DW-1:0] input_gate_pre;
  logic signed [DW-1:0] forget_gate_pre;
  logic signed [DW-1:0] output_gate_pre;
  logic signed [DW-1:0] candidate_pre;
  logic signed [DW-1:0] cell_prev;

  gate_t ig_lut;
  gate_t fg_lut;
  gate_t og_lut;

  gate_t                ig;
  gate_t                fg;
  gate_t                og;
  logic signed [DW-1:0] g;
  logic signed [DW-1:0] cp;
  logic                 last0;

  logic signed [DW-1:0] cell_b;
  gate_t                og_b;
  logic                 last_b;

  logic [DW-1:0]    cell_new;
  logic [HID_W-1:0] hidden_new;

  lrcf_stage_en_t cell_en;
  lrcf_stage_en_t hid_en;

  assign input_gate_pre  = s_tdata[0*DW +: DW];
  assign forget_gate_pre = s_tdata[1*DW +: DW];
  assign output_gate_pre = s_tdata[2*DW +: DW];
  assign candidate_pre   = s_tdata[3*DW +: DW];
  assign cell_prev       = s_tdata[4*DW +: DW];

  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || m_tready;
    for (int i = NSTG - 2; i >= 0; i--) en[i] = !vld[i] || en[i+1];
  end

  assign s_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_tvalid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  lrcf_sigmoid u_sig_i (.x(input_gate_pre),  .y(ig_lut));
  lrcf_sigmoid u_sig_f (.x(forget_gate_pre), .y(fg_lut));
  lrcf_sigmoid u_sig_o (.x(output_gate_pre), .y(og_lut));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ig    <= ig_lut;
      fg    <= s_tuser ? fg_lut : '0;
      og    <= og_lut;
      g     <= (candidate_pre < 0) ? '0 : candidate_pre;
      cp    <= cell_prev;
      last0 <= s_tlast;
    end
  end

  assign cell_en = '{load_a: en[1], load_b: en[2]};
  assign hid_en  = '{load_a: en[3], load_b: en[4]};

  lrcf_cell_path u_cell (
    .clk      (clk),
    .en       (cell_en),
    .ig       (ig),
    .fg       (fg),
    .og       (og),
    .g        (g),
    .cp       (cp),
    .last_in  (last0),
    .cell_out (cell_b),
    .og_out   (og_b),
    .last_out (last_b)
  );

  lrcf_hidden_path u_hidden (
    .clk        (clk),
    .en         (hid_en),
    .cell_in    (cell_b),
    .og         (og_b),
    .last_in    (last_b),
    .cell_new   (cell_new),
    .hidden_new (hidden_new),
    .last_out   (m_tlast)
  );

  assign m_tvalid = vld[NSTG-1];
  assign m_tdata  = OUT_DATA_W'({hidden_new, cell_new});

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("pipeline not empty after reset");

  a_backpressure_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (&vld))
    else $error("input stalled with an empty stage");

  a_hidden_nonpos: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && $signed(m_tdata[DW-1:0]) <= 0) |-> (m_tdata[DW +: HID_W] == '0))
    else $error("hidden value nonzero for nonpositive cell");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[2] && !en[2]) |=> vld[2])
    else $error("stalled cell stage lost its request");

endmodule
